>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/dct_pkg.sv
// types and constants of the call-trace ring
package dct_pkg;

    // a read returns at most this many entries
    localparam int unsigned MAX_OUT = 32;
    // width of read_count and of the walk counter
    localparam int unsigned CNT_W = 6;

    // request codes
    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  call_kind;
        logic [31:0] target_addr;
        logic [31:0] return_addr;
        logic [5:0]  read_count;
    } t_req;

    typedef struct packed {
        logic        entry_valid;
        logic [31:0] entry_seq;
        logic [31:0] entry_calls;
        logic [3:0]  entry_kind;
        logic [31:0] entry_target;
        logic [31:0] entry_return;
        logic [31:0] total_calls;
        logic [31:0] total_events;
        logic        last_item;
    } t_rsp;

    typedef struct packed {
        logic enable;
    } t_cfg;

    // one ring slot
    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] calls;
        logic [3:0]  kind;
        logic [31:0] target;
        logic [31:0] ret;
    } t_entry;

endpackage

>>> hw/rtl/dct_stream_if.sv
// valid/ready channel carrying one payload item per transfer
interface dct_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/dedup_call_trace_ring.sv
// top level of the call-trace ring recorder
//
// channels: i_cfg writes the enable bit (always ready), i_req carries record
// and read requests, o_rsp returns results; every channel moves one item per
// valid/ready transfer.
// a record request is taken in idle and gives exactly one result, which
// sits in the output register the cycle after the transfer; back-to-back
// records run at one per cycle while o_rsp keeps up.
// a read walks the ring through the slot memory, each slot in an address
// state, then a compare on the registered read data, and closes in a final
// state that hands over the last result. results come out oldest first;
// each match is held back until the next match or the close, so the
// newest match's last_item flag is known.
// the next request is taken only after the whole read has been handed over.
// reset clears counters, previous triple, enable and the control state; slot
// contents are never cleared, since every slot a read visits holds a sequence
// already stored since reset.
// when o_rsp stalls the output register holds its result and i_req drops
// ready until that result has transferred.
`include "assert_macros.svh"

module dedup_call_trace_ring #(
    parameter int unsigned RING_DEPTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dct_stream_if.sink   i_cfg,
    dct_stream_if.sink   i_req,
    dct_stream_if.source o_rsp
);
    import dct_pkg::*;

    localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned CAP   = (RING_DEPTH < MAX_OUT) ? RING_DEPTH : MAX_OUT;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(RING_DEPTH - 1);
    localparam logic [IDX_W-1:0] DEPTH_MOD = IDX_W'(RING_DEPTH);
    localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAP);

    // walk sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADDR = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    // build one result from an entry and the totals
    function automatic t_rsp f_rsp(input t_entry e, input logic v,
                                   input logic [31:0] tc, input logic [31:0] te,
                                   input logic last);
        t_rsp r;
        r.entry_valid  = v;
        r.entry_seq    = e.seq;
        r.entry_calls  = e.calls;
        r.entry_kind   = e.kind;
        r.entry_target = e.target;
        r.entry_return = e.ret;
        r.total_calls  = tc;
        r.total_events = te;
        r.last_item    = last;
        return r;
    endfunction

    logic [1:0]       r_state, n_state;
    logic             r_enable;
    logic [31:0]      r_calls, n_calls;
    logic [31:0]      r_events, n_events;
    logic [3:0]       r_prev_kind, n_prev_kind;
    logic [31:0]      r_prev_target, n_prev_target;
    logic [31:0]      r_prev_return, n_prev_return;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [31:0]      r_exp, n_exp;
    logic [CNT_W-1:0] r_left, n_left;
    t_entry           r_held, n_held;
    logic             r_held_v, n_held_v;
    t_rsp             r_out;
    logic             r_out_v;
    t_entry           r_ring [RING_DEPTH];
    t_entry           r_rd_data;

    t_req             w_req;
    logic             w_out_free;
    logic             w_req_acc;
    logic             w_changed;
    logic [31:0]      w_seq;
    logic [31:0]      w_calls_inc;
    logic [IDX_W-1:0] w_wr_idx;
    logic             w_store;
    t_entry           w_wdata;
    logic [CNT_W-1:0] w_cnt_sat;
    logic [CNT_W-1:0] w_wanted;
    logic [IDX_W-1:0] w_back;
    logic [IDX_W:0]   w_diff;
    logic [IDX_W-1:0] w_start;
    logic [31:0]      w_start_exp;
    logic [IDX_W-1:0] w_idx_next;
    logic             w_match;
    logic             w_push;
    t_rsp             w_push_data;

    // handshakes
    assign w_req      = i_req.data;
    assign w_out_free = !r_out_v || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_out_free;
    assign i_cfg.ready = 1'b1;
    assign w_req_acc  = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_out_v;
    assign o_rsp.data  = r_out;

    // record path: change detect, next sequence and ring slot
    assign w_changed   = (w_req.call_kind != r_prev_kind)
                      || (w_req.target_addr != r_prev_target)
                      || (w_req.return_addr != r_prev_return);
    assign w_seq       = (r_events == '1) ? 32'd1 : r_events + 32'd1;
    assign w_calls_inc = r_calls + 32'd1;
    assign w_wr_idx    = ((r_events == '0) || (r_events == '1)) ? '0
                       : ((r_head == LAST_IDX) ? '0 : r_head + 1'b1);
    assign w_store     = w_req_acc && (w_req.req_type == REQ_RECORD) && r_enable
                      && w_changed;
    assign w_wdata     = '{seq: w_seq, calls: w_calls_inc, kind: w_req.call_kind,
                           target: w_req.target_addr, ret: w_req.return_addr};

    // read path: entry count and the oldest slot to visit
    assign w_cnt_sat   = (w_req.read_count > CAP_CNT) ? CAP_CNT : w_req.read_count;
    assign w_wanted    = (32'(w_cnt_sat) > r_events) ? r_events[CNT_W-1:0] : w_cnt_sat;
    assign w_back      = IDX_W'(w_wanted - 1'b1);
    assign w_diff      = {1'b0, r_head} - {1'b0, w_back};
    assign w_start     = w_diff[IDX_W] ? w_diff[IDX_W-1:0] + DEPTH_MOD
                                       : w_diff[IDX_W-1:0];
    assign w_start_exp = r_events - 32'(w_wanted) + 32'd1;
    assign w_idx_next  = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
    assign w_match     = (r_rd_data.seq == r_exp);

    // sequencer and result selection
    always_comb begin
        n_state       = r_state;
        n_calls       = r_calls;
        n_events      = r_events;
        n_prev_kind   = r_prev_kind;
        n_prev_target = r_prev_target;
        n_prev_return = r_prev_return;
        n_head        = r_head;
        n_idx         = r_idx;
        n_exp         = r_exp;
        n_left        = r_left;
        n_held        = r_held;
        n_held_v      = r_held_v;
        w_push        = 1'b0;
        w_push_data   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_req_acc) begin
                    if (w_req.req_type == REQ_RECORD) begin
                        if (r_enable) begin
                            n_calls = w_calls_inc;
                            if (w_changed) begin
                                n_events      = w_seq;
                                n_head        = w_wr_idx;
                                n_prev_kind   = w_req.call_kind;
                                n_prev_target = w_req.target_addr;
                                n_prev_return = w_req.return_addr;
                            end
                        end
                        w_push      = 1'b1;
                        w_push_data = f_rsp('0, 1'b0, n_calls, n_events, 1'b1);
                    end else if (w_wanted == '0) begin
                        w_push      = 1'b1;
                        w_push_data = f_rsp('0, 1'b0, r_calls, r_events, 1'b1);
                    end else begin
                        n_idx    = w_start;
                        n_exp    = w_start_exp;
                        n_left   = w_wanted;
                        n_held_v = 1'b0;
                        n_state  = S_ADDR;
                    end
                end
            end
            S_ADDR: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                // a new match pushes out the held one, which needs the output free
                if (!(w_match && r_held_v && !w_out_free)) begin
                    if (w_match) begin
                        if (r_held_v) begin
                            w_push      = 1'b1;
                            w_push_data = f_rsp(r_held, 1'b1, r_calls, r_events, 1'b0);
                        end
                        n_held   = r_rd_data;
                        n_held_v = 1'b1;
                    end
                    n_idx   = w_idx_next;
                    n_exp   = r_exp + 32'd1;
                    n_left  = r_left - 1'b1;
                    n_state = (r_left == CNT_W'(1)) ? S_FIN : S_ADDR;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    w_push = 1'b1;
                    if (r_held_v) begin
                        w_push_data = f_rsp(r_held, 1'b1, r_calls, r_events, 1'b1);
                    end else begin
                        w_push_data = f_rsp('0, 1'b0, r_calls, r_events, 1'b1);
                    end
                    n_held_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_enable      <= 1'b0;
            r_calls       <= '0;
            r_events      <= '0;
            r_prev_kind   <= '0;
            r_prev_target <= '0;
            r_prev_return <= '0;
            r_head        <= '0;
            r_held_v      <= 1'b0;
            r_out_v       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_calls       <= n_calls;
            r_events      <= n_events;
            r_prev_kind   <= n_prev_kind;
            r_prev_target <= n_prev_target;
            r_prev_return <= n_prev_return;
            r_head        <= n_head;
            r_held_v      <= n_held_v;
            if (i_cfg.valid) begin
                r_enable <= i_cfg.data.enable;
            end
            if (w_push) begin
                r_out_v <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // walk and output payload registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_exp  <= n_exp;
        r_left <= n_left;
        r_held <= n_held;
        if (w_push) begin
            r_out <= w_push_data;
        end
    end

    // slot memory: one write port for records, one registered read port for the walk;
    // writes happen only in idle, so a walk never reads a slot being written
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_ring[w_wr_idx] <= w_wdata;
        end
        r_rd_data <= r_ring[r_idx];
    end

    // checks
    `ASSERT_IMP(a_push_free, i_clk, i_rst_n, w_push, w_out_free, "result overwrites a pending one")
    `ASSERT_IMP(a_walk_left, i_clk, i_rst_n, r_state == S_CMP, r_left != '0, "walk with no slots left")
    `ASSERT_IMP(a_head_range, i_clk, i_rst_n, 1'b1, r_head <= LAST_IDX, "ring head out of range")
    `ASSERT_NXT(a_store_seq, i_clk, i_rst_n, w_store, r_events != '0, "stored event got sequence zero")

endmodule
